// File: rtl/mmt_pkg.sv
package mmt_pkg;

  localparam int VAL_W       = 32;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int ADDR_W      = 6;
  localparam int DEPTH       = 64;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int MAX_DIM_DEF = 8;

  localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_TR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B_TR   = 3'd5;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DIM_ERR = 1'b1;

  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  typedef struct packed {
    dim_t a_rows;
    dim_t a_cols;
    logic a_tr;
    dim_t b_rows;
    dim_t b_cols;
    logic b_tr;
  } cfg_t;

  // clamped stored sizes plus the view sizes used by the walk
  typedef struct packed {
    dim_t ar;
    dim_t ac;
    dim_t br;
    dim_t bc;
    logic at;
    logic bt;
    dim_t vr_a;
    dim_t k_n;
    dim_t vc_b;
    logic mismatch;
  } dims_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic lastk;
    logic final_elem;
    logic err;
    idx_t i;
    idx_t j;
    idx_t k;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic dot_done;
  } stat_t;

  function automatic dim_t clamp_dim(dim_t d, dim_t maxd);
    dim_t r;
    if (d == '0) begin
      r = dim_t'(1);
    end else if (d > maxd) begin
      r = maxd;
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic dims_t view_dims(cfg_t c, dim_t maxd);
    dims_t d;
    dim_t  vr_b;
    d.ar   = clamp_dim(c.a_rows, maxd);
    d.ac   = clamp_dim(c.a_cols, maxd);
    d.br   = clamp_dim(c.b_rows, maxd);
    d.bc   = clamp_dim(c.b_cols, maxd);
    d.at   = c.a_tr;
    d.bt   = c.b_tr;
    d.vr_a = c.a_tr ? d.ac : d.ar;
    d.k_n  = c.a_tr ? d.ar : d.ac;
    d.vc_b = c.b_tr ? d.br : d.bc;
    vr_b   = c.b_tr ? d.bc : d.br;
    d.mismatch = (d.k_n != vr_b);
    return d;
  endfunction

endpackage

// File: rtl/mmt_if.sv
interface mmt_in_if import mmt_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  addr_t element_index;
  val_t  element_value;

  modport source(output valid, func, element_index, element_value, input ready);
  modport sink(input valid, func, element_index, element_value, output ready);
endinterface

interface mmt_out_if import mmt_pkg::*; ();
  logic valid;
  logic ready;
  idx_t out_row;
  idx_t out_col;
  val_t out_value;
  logic status;
  logic last;

  modport source(output valid, out_row, out_col, out_value, status, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

// File: rtl/mmt_ctrl.sv
module mmt_ctrl import mmt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  dims_t dims,
  input  logic  in_accept,
  input  func_t in_func,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  idx_t       i_r, i_nxt;
  idx_t       j_r, j_nxt;
  idx_t       k_r, k_nxt;
  logic       lastk, last_i, last_j;

  assign lastk  = (DIM_W'(k_r) + dim_t'(1)) == dims.k_n;
  assign last_i = (DIM_W'(i_r) + dim_t'(1)) == dims.vr_a;
  assign last_j = (DIM_W'(j_r) + dim_t'(1)) == dims.vc_b;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd            = '0;
    cmd.i          = i_r;
    cmd.j          = j_r;
    cmd.k          = k_r;
    cmd.first      = (k_r == '0);
    cmd.lastk      = lastk;
    cmd.final_elem = last_i && last_j;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_func == FUNC_COMPUTE) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!stat.out_busy) begin
          if (dims.mismatch) begin
            cmd.err   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (lastk) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + idx_t'(1);
        end
      end
      S_WAIT: begin
        if (stat.dot_done) begin
          if (last_i && last_j) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_START;
            if (last_j) begin
              j_nxt = '0;
              i_nxt = i_r + idx_t'(1);
            end else begin
              j_nxt = j_r + idx_t'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// File: rtl/mmt_dp.sv
module mmt_dp import mmt_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  dims_t dims,
  input  logic  wr_en,
  input  func_t wr_func,
  input  addr_t wr_addr,
  input  val_t  wr_data,
  input  cmd_t  cmd,
  output stat_t stat,
  input  logic  out_take,
  output logic  out_valid,
  output idx_t  out_row,
  output idx_t  out_col,
  output val_t  out_value,
  output logic  out_status,
  output logic  out_last
);

  localparam int ACC_W = 2 * VAL_W + $clog2(MAX_DIM) + 1;
  localparam int SH_W  = ACC_W - 16;
  localparam int MUL_W = 2 * ADDR_W + 1;

  typedef struct packed {
    logic first;
    logic lastk;
    logic final_elem;
    idx_t i;
    idx_t j;
  } tag_t;

  val_t mem_a [DEPTH];
  val_t mem_b [DEPTH];

  logic [MUL_W-1:0] lin_a, lin_b;
  addr_t addr_a, addr_b;

  val_t                     rda_r, rdb_r;
  logic                     v1_r, v2_r, fin_r;
  tag_t                     t1_r, t2_r, tf_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic signed [SH_W-1:0]   sh;
  logic [SH_W-VAL_W:0]      sh_top;
  val_t                     sat_val;

  logic out_valid_r;
  idx_t out_row_r, out_col_r;
  val_t out_value_r;
  logic out_status_r, out_last_r;

  // view addresses: A(i,k) and B(k,j), row-major or transposed
  always_comb begin
    if (dims.at) begin
      lin_a = MUL_W'(cmd.k) * MUL_W'(dims.ar) + MUL_W'(cmd.i);
    end else begin
      lin_a = MUL_W'(cmd.i) * MUL_W'(dims.ac) + MUL_W'(cmd.k);
    end
    if (dims.bt) begin
      lin_b = MUL_W'(cmd.j) * MUL_W'(dims.br) + MUL_W'(cmd.k);
    end else begin
      lin_b = MUL_W'(cmd.k) * MUL_W'(dims.bc) + MUL_W'(cmd.j);
    end
    addr_a = lin_a[ADDR_W-1:0];
    addr_b = lin_b[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_func == FUNC_WR_A) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_en && wr_func == FUNC_WR_B) begin
      mem_b[wr_addr] <= wr_data;
    end
    rda_r <= mem_a[addr_a];
    rdb_r <= mem_b[addr_b];
  end

  assign acc_sum = (t2_r.first ? '0 : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    t1_r   <= '{first: cmd.first, lastk: cmd.lastk, final_elem: cmd.final_elem,
                i: cmd.i, j: cmd.j};
    t2_r   <= t1_r;
    prod_r <= rda_r * rdb_r;
    if (v2_r) begin
      acc_r <= acc_sum;
      tf_r  <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      v1_r  <= cmd.issue;
      v2_r  <= v1_r;
      fin_r <= v2_r && t2_r.lastk;
    end
  end

  // floor divide by 2^16, then saturate to Q16.16
  always_comb begin
    sh     = acc_r[ACC_W-1:16];
    sh_top = sh[SH_W-1:VAL_W-1];
    if (&sh_top || ~|sh_top) begin
      sat_val = sh[VAL_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_r || cmd.err) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_value_r  <= '0;
      out_status_r <= STATUS_DIM_ERR;
      out_last_r   <= 1'b1;
    end else if (fin_r) begin
      out_row_r    <= tf_r.i;
      out_col_r    <= tf_r.j;
      out_value_r  <= sat_val;
      out_status_r <= STATUS_OK;
      out_last_r   <= tf_r.final_elem;
    end
  end

  assign stat.out_busy = out_valid_r;
  assign stat.dot_done = fin_r;

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/matrix_multiply_transposable.sv
// Signed Q16.16 matrix multiplier with optional transposed views of A and B.
// Element write beats (func 0 for A, 1 for B) produce no result; func 3 is
// dropped. A compute beat walks the product row by row through one shared
// multiply-accumulate pipe fed by a single read port on each 64-entry store,
// so result elements come one at a time; the next one starts only after the
// previous result has been taken. The exact sum is floored to Q16.16 and
// saturated to 32 bits. A mismatch of inner dimensions gives one result with
// status 1 and last set.
// Stores come up unwritten after reset; load every element a run will read.
// Write configuration only while no compute run is in flight.
module matrix_multiply_transposable import mmt_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mmt_in_if.sink                in_ch,
  mmt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  dims_t dims;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows <= dim_t'(1);
      cfg_r.a_cols <= dim_t'(1);
      cfg_r.a_tr   <= 1'b0;
      cfg_r.b_rows <= dim_t'(1);
      cfg_r.b_cols <= dim_t'(1);
      cfg_r.b_tr   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_ROWS: cfg_r.a_rows <= cfg_data;
        CFG_A_COLS: cfg_r.a_cols <= cfg_data;
        CFG_A_TR:   cfg_r.a_tr   <= cfg_data[0];
        CFG_B_ROWS: cfg_r.b_rows <= cfg_data;
        CFG_B_COLS: cfg_r.b_cols <= cfg_data;
        CFG_B_TR:   cfg_r.b_tr   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dims      = view_dims(cfg_r, DIM_W'(MAX_DIM));
  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  mmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .in_accept (in_accept),
    .in_func   (in_ch.func),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mmt_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .wr_en      (in_accept),
    .wr_func    (in_ch.func),
    .wr_addr    (in_ch.element_index),
    .wr_data    (in_ch.element_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_take   (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_row    (out_ch.out_row),
    .out_col    (out_ch.out_col),
    .out_value  (out_ch.out_value),
    .out_status (out_ch.status),
    .out_last   (out_ch.last)
  );

endmodule

// File: test/matrix_multiply_transposable_tb.sv
module matrix_multiply_transposable_tb;
  import mmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    CYCLE_LIMIT = 600_000;
  localparam int    SETTLE_CYCLES = 32;
  localparam int    HOLD_CYCLES = 400;
  localparam int    RANDOM_BEATS = 95;
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    func_t func;
    addr_t element_index;
    val_t  element_value;
  } beat_t;

  typedef struct packed {
    idx_t out_row;
    idx_t out_col;
    val_t out_value;
    logic status;
    logic last;
  } result_t;

  typedef struct packed {
    row_kind_t kind;
    logic [2:0] code;
    addr_t     index;
    val_t      value;
    logic      typed;
    result_t   res;
  } tab_row_t;

  localparam result_t NO_RES = '0;
  localparam val_t EDGE_VALS [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

  // directed rows: element writes, 1x1 extremes, a dropped func 3 beat, dimension errors, clamped sizes, transposes
  tab_row_t dir_tab [$] = '{
    '{ROW_BEAT, 3'(FUNC_WR_A),    6'd0,  32'h0001_0000, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_WR_B),    6'd0,  32'h7FFF_FFFF, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'h7FFF_FFFF, STATUS_OK, 1'b1}},
    '{ROW_BEAT, 3'(FUNC_WR_A),    6'd0,  32'h8000_0000, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_WR_B),    6'd0,  32'h8000_0000, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'h7FFF_FFFF, STATUS_OK, 1'b1}},
    '{ROW_BEAT, 3'(FUNC_WR_B),    6'd0,  32'h7FFF_FFFF, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'h8000_0000, STATUS_OK, 1'b1}},
    '{ROW_BEAT, 3'(FUNC_WR_A),    6'd0,  32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_WR_B),    6'd0,  32'h0000_0001, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'hFFFF_FFFF, STATUS_OK, 1'b1}},
    '{ROW_BEAT, 3'(FUNC_UNUSED),  6'd0,  32'h1234_5678, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'hFFFF_FFFF, STATUS_OK, 1'b1}},
    '{ROW_BEAT, 3'(FUNC_WR_A),    6'd63, 32'h5A5A_A5A5, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_WR_B),    6'd63, 32'h8000_0000, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_COLS,       6'd0,  32'd2, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'h0, STATUS_DIM_ERR, 1'b1}},
    '{ROW_REG,  CFG_B_ROWS,       6'd0,  32'd2, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_TR,         6'd0,  32'd1, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b1,
      '{3'd0, 3'd0, 32'h0, STATUS_DIM_ERR, 1'b1}},
    '{ROW_REG,  CFG_B_TR,         6'd0,  32'd1, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_ROWS,       6'd0,  32'd0, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_COLS,       6'd0,  32'd15, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_TR,         6'd0,  32'hE, 1'b0, NO_RES},
    '{ROW_REG,  CFG_B_ROWS,       6'd0,  32'd0, 1'b0, NO_RES},
    '{ROW_REG,  CFG_B_COLS,       6'd0,  32'd15, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b0, NO_RES},
    '{ROW_REG,  CFG_B_TR,         6'd0,  32'h2, 1'b0, NO_RES},
    '{ROW_REG,  CFG_A_TR,         6'd0,  32'h3, 1'b0, NO_RES},
    '{ROW_BEAT, 3'(FUNC_COMPUTE), 6'd0,  32'h0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mmt_in_if  in_ch ();
  mmt_out_if out_ch ();

  matrix_multiply_transposable i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cfg_t    regs_shadow = '{4'd1, 4'd1, 1'b0, 4'd1, 4'd1, 1'b0};
  val_t    shadow_a [DEPTH];
  val_t    shadow_b [DEPTH];
  bit      loaded_a [DEPTH];
  bit      loaded_b [DEPTH];
  result_t expected_products [$];
  int      mismatches = 0;
  int      elements_and_runs = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  function automatic int fit_dim(dim_t d);
    if (d == '0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  function automatic void view_shape(output int ar, output int ac, output int br, output int bc,
                                     output int rows, output int inner, output int cols,
                                     output bit clash);
    ar    = fit_dim(regs_shadow.a_rows);
    ac    = fit_dim(regs_shadow.a_cols);
    br    = fit_dim(regs_shadow.b_rows);
    bc    = fit_dim(regs_shadow.b_cols);
    rows  = regs_shadow.a_tr ? ac : ar;
    inner = regs_shadow.a_tr ? ar : ac;
    cols  = regs_shadow.b_tr ? br : bc;
    clash = inner != (regs_shadow.b_tr ? bc : br);
  endfunction

  // exact Q32.32 sum, floored to Q16.16, saturated to 32 bits
  function automatic void predict_product();
    int ar, ac, br, bc, rows, inner, cols;
    bit clash;
    logic signed [79:0] acc;
    logic signed [79:0] floored;
    result_t r;
    view_shape(ar, ac, br, bc, rows, inner, cols, clash);
    if (clash) begin
      r = '0;
      r.status = STATUS_DIM_ERR;
      r.last = 1'b1;
      expected_products.push_back(r);
    end else begin
      for (int i = 0; i < rows; i++) begin
        for (int j = 0; j < cols; j++) begin
          acc = '0;
          for (int k = 0; k < inner; k++) begin
            acc += longint'(shadow_a[regs_shadow.a_tr ? k * ar + i : i * ac + k]) *
                   longint'(shadow_b[regs_shadow.b_tr ? j * br + k : k * bc + j]);
          end
          floored = acc >>> 16;
          r.out_row = idx_t'(i);
          r.out_col = idx_t'(j);
          if (floored > 80'sd2147483647) begin
            r.out_value = 32'h7FFF_FFFF;
          end else if (floored < -80'sd2147483648) begin
            r.out_value = 32'h8000_0000;
          end else begin
            r.out_value = floored[31:0];
          end
          r.status = STATUS_OK;
          r.last = (i == rows - 1) && (j == cols - 1);
          expected_products.push_back(r);
        end
      end
    end
  endfunction

  function automatic void apply_beat(beat_t b);
    case (b.func)
      FUNC_WR_A: begin
        shadow_a[b.element_index] = b.element_value;
        loaded_a[b.element_index] = 1'b1;
      end
      FUNC_WR_B: begin
        shadow_b[b.element_index] = b.element_value;
        loaded_b[b.element_index] = 1'b1;
      end
      FUNC_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  function automatic val_t rand_value();
    val_t v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = EDGE_VALS[$urandom_range(3)];
      2: v = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: v = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] code_dim(int d);
    if (d == 1 && $urandom_range(2) == 0) return '0;
    if (d == MAX_DIM_DEF && $urandom_range(1) == 1) return CFG_DATA_W'($urandom_range(9, 15));
    return CFG_DATA_W'(d);
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input result_t typed_res);
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= b.func;
    in_ch.element_index <= b.element_index;
    in_ch.element_value <= b.element_value;
    do @(posedge clk); while (!in_ch.ready);
    if (b.func != FUNC_UNUSED) elements_and_runs++;
    if (typed) expected_products.push_back(typed_res);
    else apply_beat(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_A_ROWS: regs_shadow.a_rows = data;
      CFG_A_COLS: regs_shadow.a_cols = data;
      CFG_A_TR:   regs_shadow.a_tr = data[0];
      CFG_B_ROWS: regs_shadow.b_rows = data;
      CFG_B_COLS: regs_shadow.b_cols = data;
      CFG_B_TR:   regs_shadow.b_tr = data[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // every element a product run reads gets written first
  task automatic fill_operands();
    int ar, ac, br, bc, rows, inner, cols;
    bit clash;
    beat_t b;
    view_shape(ar, ac, br, bc, rows, inner, cols, clash);
    if (!clash) begin
      for (int e = 0; e < ar * ac; e++) begin
        if (!loaded_a[e]) begin
          b = '{FUNC_WR_A, addr_t'(e), rand_value()};
          send_beat(b, 1'b0, NO_RES);
        end
      end
      for (int e = 0; e < br * bc; e++) begin
        if (!loaded_b[e]) begin
          b = '{FUNC_WR_B, addr_t'(e), rand_value()};
          send_beat(b, 1'b0, NO_RES);
        end
      end
    end
  endtask

  task automatic pick_shape(input bit full);
    int m, k, n, ar, ac, br, bc;
    bit at, bt;
    m  = full ? MAX_DIM_DEF : $urandom_range(1, 3);
    k  = full ? 1 : $urandom_range(1, 3);
    n  = full ? MAX_DIM_DEF : $urandom_range(1, 3);
    at = 1'($urandom_range(1));
    bt = 1'($urandom_range(1));
    ar = at ? k : m;
    ac = at ? m : k;
    br = bt ? n : k;
    bc = bt ? k : n;
    if ($urandom_range(6) == 0) begin
      br = $urandom_range(1, MAX_DIM_DEF);
      bc = $urandom_range(1, MAX_DIM_DEF);
    end
    write_reg(CFG_A_ROWS, code_dim(ar));
    write_reg(CFG_A_COLS, code_dim(ac));
    write_reg(CFG_A_TR, {3'($urandom_range(7)), at});
    write_reg(CFG_B_ROWS, code_dim(br));
    write_reg(CFG_B_COLS, code_dim(bc));
    write_reg(CFG_B_TR, {3'($urandom_range(7)), bt});
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    result_t want;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_products.size() == 0) begin
          $error("result beat with nothing expected: row %0d col %0d value %0h",
                 out_ch.out_row, out_ch.out_col, out_ch.out_value);
          mismatches++;
        end else begin
          want = expected_products.pop_front();
          check_field("out_row", 32'(want.out_row), 32'(out_ch.out_row));
          check_field("out_col", 32'(want.out_col), 32'(out_ch.out_col));
          check_field("out_value", want.out_value, out_ch.out_value);
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 6);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** matrix_multiply_transposable: FAILED **");
    $finish;
  end

  initial begin : stimulus
    beat_t b;
    bit idle;
    int phase, runs, start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WR_A;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle = 1'b1;
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_REG) begin
        if (!idle) settle();
        idle = 1'b1;
        write_reg(dir_tab[r].code, dir_tab[r].value[CFG_DATA_W-1:0]);
      end else begin
        b = '{dir_tab[r].code[FUNC_W-1:0], dir_tab[r].index, dir_tab[r].value};
        if (b.func == FUNC_COMPUTE) fill_operands();
        send_beat(b, dir_tab[r].typed, dir_tab[r].res);
        idle = 1'b0;
      end
    end

    phase = 0;
    start = elements_and_runs;
    while (elements_and_runs - start < RANDOM_BEATS) begin
      settle();
      calm = (phase >= 3) && (phase <= 5);
      pick_shape(phase % 9 == 8);
      if (phase == 1) hold_req = 1'b1;
      runs = (phase == 1) ? 3 : $urandom_range(1, 3);
      repeat (runs) begin
        repeat ($urandom_range(0, 4)) begin
          b.func = $urandom_range(1) ? FUNC_WR_A : FUNC_WR_B;
          b.element_index = addr_t'($urandom_range(DEPTH - 1));
          b.element_value = rand_value();
          send_beat(b, 1'b0, NO_RES);
        end
        if ($urandom_range(5) == 0) begin
          b = '{FUNC_UNUSED, addr_t'($urandom_range(DEPTH - 1)), rand_value()};
          send_beat(b, 1'b0, NO_RES);
        end
        fill_operands();
        b = '{FUNC_COMPUTE, addr_t'($urandom_range(DEPTH - 1)), val_t'($urandom)};
        send_beat(b, 1'b0, NO_RES);
      end
      phase++;
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("** matrix_multiply_transposable: PASSED **");
    end else begin
      $display("** matrix_multiply_transposable: FAILED **");
    end
    $finish;
  end

endmodule
